// ===== rtl/htfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder package
// Shared constants, the record passed between the frame and scaling stages,
// and the byte-wide CRC-8 update used on the incoming sensor bytes.
// ----------------------------------------------------------------------------
package htfd_pkg;

	localparam int          RAW_W       = 20;
	localparam int          HUM_W       = 14;
	localparam int          TEMP_W      = 15;
	localparam int          FRAC_BITS   = 20;
	localparam int          HUM_PROD_W  = RAW_W + HUM_W;
	localparam int          TEMP_PROD_W = RAW_W + TEMP_W;

	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam int          BUSY_BIT    = 7;

	localparam logic [2:0]  POS_STATUS  = 3'd0;
	localparam logic [2:0]  POS_FIRST   = 3'd1;
	localparam logic [2:0]  POS_CRC     = 3'd6;

	localparam logic [HUM_W-1:0]  HUM_SCALE   = HUM_W'(10000);
	localparam logic [TEMP_W-1:0] TEMP_SCALE  = TEMP_W'(20000);
	localparam logic [TEMP_W:0]   TEMP_OFFSET = (TEMP_W + 1)'(5000);

	typedef struct packed {
		logic             not_ready;
		logic             crc_error;
		logic [RAW_W-1:0] hum_raw;
		logic [RAW_W-1:0] temp_raw;
	} htfd_raw_t;

	// One CRC-8 step over a full byte, most significant bit first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== rtl/humidity_temperature_frame_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder
// Decodes the seven-byte sensor response into raw and scaled readings.
// ----------------------------------------------------------------------------
// One byte request is taken per clock cycle while in_stall is low. The frame
// tracker updates the position, CRC and data bytes as each byte is taken and
// registers a raw result on the CRC byte or on a busy status byte; the scaler
// multiplies the raw values by constants and loads the output register when
// it can advance. A result is thus registered first in the frame tracker and
// then in the output register, and the bytes of the next frame keep flowing
// while it waits to be taken, until a second result is ready behind it.
module humidity_temperature_frame_decoder_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               frame_start,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               not_ready,
	output logic                               crc_error,
	output logic [htfd_pkg::RAW_W-1:0]         humidity_raw_value,
	output logic [htfd_pkg::RAW_W-1:0]         temperature_raw_value,
	output logic [htfd_pkg::HUM_W-1:0]         humidity_hundredths,
	output logic signed [htfd_pkg::TEMP_W-1:0] temperature_hundredths
);

	logic                res_valid_s1;
	htfd_pkg::htfd_raw_t res_s1;
	logic                adv;

	htfd_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.frame_start  (frame_start),
		.adv          (adv),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1)
	);

	htfd_scale u_scale (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.res_valid_s1           (res_valid_s1),
		.res_s1                 (res_s1),
		.adv                    (adv),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.not_ready              (not_ready),
		.crc_error              (crc_error),
		.humidity_raw_value     (humidity_raw_value),
		.temperature_raw_value  (temperature_raw_value),
		.humidity_hundredths    (humidity_hundredths),
		.temperature_hundredths (temperature_hundredths)
	);

endmodule

// ===== rtl/htfd_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame tracker
// Follows the byte position inside the sensor response, runs the CRC, keeps
// the five data bytes and registers one raw result per finished or busy frame.
// ----------------------------------------------------------------------------
module htfd_frame (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                frame_start,
	input  logic                adv,
	output logic                res_valid_s1,
	output htfd_pkg::htfd_raw_t res_s1
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [39:0] payload_q;
	logic        accept;
	logic        is_status;
	logic        busy;
	logic        emit;
	logic [7:0]  crc_next;

	assign in_stall  = res_valid_s1 & ~adv;
	assign accept    = in_valid & ~in_stall;
	assign is_status = frame_start | (pos_q == htfd_pkg::POS_STATUS) | (pos_q > htfd_pkg::POS_CRC);
	assign busy      = is_status & data_byte[htfd_pkg::BUSY_BIT];
	assign emit      = busy | (~is_status & (pos_q == htfd_pkg::POS_CRC));
	assign crc_next  = htfd_pkg::crc8_byte(is_status ? htfd_pkg::CRC_INIT : crc_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= htfd_pkg::POS_STATUS;
			crc_q        <= htfd_pkg::CRC_INIT;
			res_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				res_valid_s1 <= emit;
				if (emit) begin
					pos_q <= htfd_pkg::POS_STATUS;
					crc_q <= htfd_pkg::CRC_INIT;
				end else if (is_status) begin
					pos_q <= htfd_pkg::POS_FIRST;
					crc_q <= crc_next;
				end else begin
					pos_q <= pos_q + 3'd1;
					crc_q <= crc_next;
				end
			end else if (adv) begin
				res_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_status && !emit) begin
			payload_q <= {payload_q[31:0], data_byte};
		end
		if (accept && emit) begin
			res_s1.not_ready <= busy;
			res_s1.crc_error <= ~busy & (crc_q != data_byte);
			res_s1.hum_raw   <= busy ? '0 : payload_q[39:20];
			res_s1.temp_raw  <= busy ? '0 : payload_q[19:0];
		end
	end

endmodule

// ===== rtl/htfd_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result scaler
// Converts the raw readings to hundredths of a percent and of a degree and
// holds the finished result in the output register.
// ----------------------------------------------------------------------------
module htfd_scale (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  res_valid_s1,
	input  htfd_pkg::htfd_raw_t                   res_s1,
	output logic                                  adv,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  not_ready,
	output logic                                  crc_error,
	output logic [htfd_pkg::RAW_W-1:0]            humidity_raw_value,
	output logic [htfd_pkg::RAW_W-1:0]            temperature_raw_value,
	output logic [htfd_pkg::HUM_W-1:0]            humidity_hundredths,
	output logic signed [htfd_pkg::TEMP_W-1:0]    temperature_hundredths
);

	logic [htfd_pkg::HUM_PROD_W-1:0]  hum_prod;
	logic [htfd_pkg::TEMP_PROD_W-1:0] temp_prod;
	logic [htfd_pkg::TEMP_W-1:0]      temp_scaled;
	logic signed [htfd_pkg::TEMP_W:0] temp_off;

	assign hum_prod    = htfd_pkg::HUM_PROD_W'(res_s1.hum_raw)
	                     * htfd_pkg::HUM_PROD_W'(htfd_pkg::HUM_SCALE);
	assign temp_prod   = htfd_pkg::TEMP_PROD_W'(res_s1.temp_raw)
	                     * htfd_pkg::TEMP_PROD_W'(htfd_pkg::TEMP_SCALE);
	assign temp_scaled = temp_prod[htfd_pkg::TEMP_PROD_W-1:htfd_pkg::FRAC_BITS];
	assign temp_off    = $signed({1'b0, temp_scaled}) - $signed(htfd_pkg::TEMP_OFFSET);
	assign adv         = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= res_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid_s1) begin
			not_ready             <= res_s1.not_ready;
			crc_error             <= res_s1.crc_error;
			humidity_raw_value    <= res_s1.hum_raw;
			temperature_raw_value <= res_s1.temp_raw;
			humidity_hundredths   <= hum_prod[htfd_pkg::HUM_PROD_W-1:htfd_pkg::FRAC_BITS];
			temperature_hundredths <= res_s1.not_ready ? '0 : temp_off[htfd_pkg::TEMP_W-1:0];
		end
	end

endmodule

// ===== rtl/htfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder checker
// Watches the ports of the decoder for result consistency, output holding and input stalls.
// ----------------------------------------------------------------------------
module htfd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               not_ready,
	input logic                               crc_error,
	input logic [htfd_pkg::RAW_W-1:0]         humidity_raw_value,
	input logic [htfd_pkg::RAW_W-1:0]         temperature_raw_value,
	input logic [htfd_pkg::HUM_W-1:0]         humidity_hundredths,
	input logic signed [htfd_pkg::TEMP_W-1:0] temperature_hundredths
);

	// A busy result carries no readings and no CRC flag.
	a_busy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_ready |-> !crc_error && humidity_raw_value == '0
		&& temperature_raw_value == '0 && humidity_hundredths == '0
		&& temperature_hundredths == '0)
		else $error("busy result carries nonzero fields");

	// Humidity stays below one hundred percent.
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_hundredths <= htfd_pkg::HUM_W'(9999))
		else $error("humidity out of range");

	// Temperature stays within the sensor range.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_hundredths >= -16'sd5000
		&& temperature_hundredths <= 16'sd14999)
		else $error("temperature out of range");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// The input is never held off while the output register is empty.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output");

endmodule

bind humidity_temperature_frame_decoder_top htfd_checker u_htfd_checker (.*);

// ===== sim/humidity_temperature_frame_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder testbench
// Sends sensor response bytes through the byte request channel. A local
// decoder or a typed table row predicts every not-ready and reading result,
// and a scoreboard compares each result field against the oldest prediction.
// A short table covers the corner cases, then mostly well-formed random frames
// with truncated frames and stray bytes mixed in, under random valid and stall.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder_top_tb;

	localparam int RANDOM_BYTES   = 1400;
	localparam int STALL_PERCENT  = 37;
	localparam int HOLD_CYCLES    = 60;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DIRECTED_ROWS  = 25;

	typedef enum logic [1:0] {
		CRC_LITERAL,
		CRC_MATCH,
		CRC_FLIP
	} crc_mode_e;

	typedef struct packed {
		logic                               not_ready;
		logic                               crc_error;
		logic [htfd_pkg::RAW_W-1:0]         hum_raw;
		logic [htfd_pkg::RAW_W-1:0]         temp_raw;
		logic [htfd_pkg::HUM_W-1:0]         hum_h;
		logic signed [htfd_pkg::TEMP_W-1:0] temp_h;
	} reading_t;

	typedef struct {
		logic [7:0] data;
		logic       start;
		crc_mode_e  mode;
		bit         typed;
		reading_t   want;
	} stim_row_t;

	localparam reading_t NO_READING   = '0;
	localparam reading_t BUSY_READING = '{1'b1, 1'b0, 20'h0, 20'h0, 14'd0, 15'sd0};
	localparam reading_t ZERO_READING = '{1'b0, 1'b0, 20'h0, 20'h0, 14'd0, -15'sd5000};
	localparam reading_t MAX_READING  =
		'{1'b0, 1'b1, 20'hFFFFF, 20'hFFFFF, 14'd9999, 15'sd14999};

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'hFF, 1'b0, CRC_LITERAL, 1'b1, BUSY_READING},
		'{8'h00, 1'b1, CRC_LITERAL, 1'b0, NO_READING},
		'{8'hC5, 1'b1, CRC_LITERAL, 1'b1, BUSY_READING},
		'{8'h00, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h00, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h00, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h00, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h00, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h00, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h00, 1'b0, CRC_MATCH,   1'b1, ZERO_READING},
		'{8'h7F, 1'b1, CRC_LITERAL, 1'b0, NO_READING},
		'{8'hFF, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'hFF, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'hFF, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'hFF, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'hFF, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h00, 1'b0, CRC_FLIP,    1'b1, MAX_READING},
		'{8'h1C, 1'b1, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h18, 1'b1, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h56, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h78, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h9A, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'hBC, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'hDE, 1'b0, CRC_LITERAL, 1'b0, NO_READING},
		'{8'h00, 1'b0, CRC_MATCH,   1'b0, NO_READING}
	};

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic [7:0]                         data_byte;
	logic                               frame_start;
	logic                               out_valid;
	logic                               out_stall;
	logic                               not_ready;
	logic                               crc_error;
	logic [htfd_pkg::RAW_W-1:0]         humidity_raw_value;
	logic [htfd_pkg::RAW_W-1:0]         temperature_raw_value;
	logic [htfd_pkg::HUM_W-1:0]         humidity_hundredths;
	logic signed [htfd_pkg::TEMP_W-1:0] temperature_hundredths;

	logic [2:0]  frame_pos;
	logic [7:0]  frame_crc;
	logic [39:0] frame_payload;

	reading_t pending_readings [$];
	reading_t got;
	reading_t oldest;
	int       errors;
	int       stuck_cycles;
	int       bytes_accepted;
	int       readings_seen;
	int       busy_seen;
	int       crc_errors_seen;
	bit       idle_on;
	bit       hold_req;

	humidity_temperature_frame_decoder_top i_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.data_byte              (data_byte),
		.frame_start            (frame_start),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.not_ready              (not_ready),
		.crc_error              (crc_error),
		.humidity_raw_value     (humidity_raw_value),
		.temperature_raw_value  (temperature_raw_value),
		.humidity_hundredths    (humidity_hundredths),
		.temperature_hundredths (temperature_hundredths)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c  = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic s, output reading_t r);
		logic [33:0] hum_prod;
		logic [34:0] temp_prod;
		logic [14:0] temp_q;
		r = NO_READING;
		if (s || frame_pos == htfd_pkg::POS_STATUS || frame_pos > htfd_pkg::POS_CRC) begin
			if (b[htfd_pkg::BUSY_BIT]) begin
				frame_pos   = htfd_pkg::POS_STATUS;
				frame_crc   = htfd_pkg::CRC_INIT;
				r.not_ready = 1'b1;
				return 1'b1;
			end
			frame_crc     = crc8_shift(htfd_pkg::CRC_INIT, b);
			frame_payload = '0;
			frame_pos     = htfd_pkg::POS_FIRST;
			return 1'b0;
		end
		if (frame_pos < htfd_pkg::POS_CRC) begin
			frame_crc     = crc8_shift(frame_crc, b);
			frame_payload = {frame_payload[31:0], b};
			frame_pos     = frame_pos + 3'd1;
			return 1'b0;
		end
		r.crc_error = (frame_crc != b);
		r.hum_raw   = frame_payload[39:20];
		r.temp_raw  = frame_payload[19:0];
		hum_prod    = r.hum_raw * 34'd10000;
		temp_prod   = r.temp_raw * 35'd20000;
		temp_q      = temp_prod[34:20];
		r.hum_h     = hum_prod[33:20];
		r.temp_h    = temp_q - 15'd5000;
		frame_pos   = htfd_pkg::POS_STATUS;
		frame_crc   = htfd_pkg::CRC_INIT;
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic s, input crc_mode_e mode,
			input bit typed, input reading_t want);
		logic [7:0] value;
		reading_t   r;
		while (idle_on && $urandom_range(99) < STALL_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		case (mode)
			CRC_MATCH: value = frame_crc;
			CRC_FLIP:  value = frame_crc ^ 8'h01;
			default:   value = b;
		endcase
		in_valid    <= 1'b1;
		data_byte   <= value;
		frame_start <= s;
		do @(posedge clk); while (in_stall);
		bytes_accepted++;
		if (decode_byte(value, s, r)) begin
			pending_readings.push_back(typed ? want : r);
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < STALL_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stuck_cycles <= 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles <= 0;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
			if (out_valid && !out_stall) begin
				got = '{not_ready, crc_error, humidity_raw_value, temperature_raw_value,
					humidity_hundredths, temperature_hundredths};
				readings_seen++;
				if (not_ready) busy_seen++;
				if (crc_error) crc_errors_seen++;
				if (pending_readings.size() == 0) begin
					$error("Result arrived with no pending request");
					errors++;
				end else begin
					oldest = pending_readings.pop_front();
					if (got.not_ready !== oldest.not_ready) begin
						$error("not_ready: expected %0d, actual %0d",
							oldest.not_ready, got.not_ready);
						errors++;
					end
					if (got.crc_error !== oldest.crc_error) begin
						$error("crc_error: expected %0d, actual %0d",
							oldest.crc_error, got.crc_error);
						errors++;
					end
					if (got.hum_raw !== oldest.hum_raw) begin
						$error("humidity_raw_value: expected 0x%05h, actual 0x%05h",
							oldest.hum_raw, got.hum_raw);
						errors++;
					end
					if (got.temp_raw !== oldest.temp_raw) begin
						$error("temperature_raw_value: expected 0x%05h, actual 0x%05h",
							oldest.temp_raw, got.temp_raw);
						errors++;
					end
					if (got.hum_h !== oldest.hum_h) begin
						$error("humidity_hundredths: expected %0d, actual %0d",
							oldest.hum_h, got.hum_h);
						errors++;
					end
					if (got.temp_h !== oldest.temp_h) begin
						$error("temperature_hundredths: expected %0d, actual %0d",
							oldest.temp_h, got.temp_h);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		do @(posedge clk); while (stuck_cycles < WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [7:0] st;
		int         kind;
		int         n;
		bit         hold_done;
		bit         pause_done;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_byte     = 8'h00;
		frame_start   = 1'b0;
		idle_on       = 1'b1;
		hold_req      = 1'b0;
		hold_done     = 1'b0;
		pause_done    = 1'b0;
		errors        = 0;
		frame_pos     = htfd_pkg::POS_STATUS;
		frame_crc     = htfd_pkg::CRC_INIT;
		frame_payload = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].data, directed_rows[i].start, directed_rows[i].mode,
				directed_rows[i].typed, directed_rows[i].want);
		end

		while (bytes_accepted < DIRECTED_ROWS + RANDOM_BYTES) begin
			n = bytes_accepted - DIRECTED_ROWS;
			if (!hold_done && n >= 300) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && n >= 700) begin
				pause_done = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_readings.size() != 0) @(posedge clk);
			end
			idle_on = !(n >= 900 && n < 1150);
			kind = int'($urandom_range(99));
			if (kind < 85) begin
				st = 8'($urandom_range(255));
				if ($urandom_range(9) != 0) st[htfd_pkg::BUSY_BIT] = 1'b0;
				send_byte(st, $urandom_range(4) != 0, CRC_LITERAL, 1'b0, NO_READING);
				if (!st[htfd_pkg::BUSY_BIT]) begin
					repeat (5) begin
						case ($urandom_range(9))
							0:       st = 8'h00;
							1:       st = 8'hFF;
							default: st = 8'($urandom_range(255));
						endcase
						send_byte(st, 1'b0, CRC_LITERAL, 1'b0, NO_READING);
					end
					send_byte(8'($urandom_range(255)), 1'b0,
						($urandom_range(4) != 0) ? CRC_MATCH : CRC_LITERAL, 1'b0, NO_READING);
				end
			end else begin
				repeat ($urandom_range(6, 1)) begin
					send_byte(8'($urandom_range(255)), $urandom_range(3) == 0, CRC_LITERAL,
						1'b0, NO_READING);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes: directed corner frames, then random frames and noise.",
			bytes_accepted);
		$display("Checked %0d results: %0d not ready, %0d with CRC mismatch.",
			readings_seen, busy_seen, crc_errors_seen);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== humidity_temperature_frame_decoder_top.f =====
rtl/htfd_pkg.sv
rtl/htfd_frame.sv
rtl/htfd_scale.sv
rtl/humidity_temperature_frame_decoder_top.sv
rtl/htfd_checker.sv
sim/humidity_temperature_frame_decoder_top_tb.sv
